// ----- rtl/core/mtbc_pkg.sv -----
`timescale 1ns / 1ps

package mtbc_pkg;

    // Default sizes handed to the top level parameters
    localparam int TAG_CHARS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 64;

    // Fixed result field widths
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Characters with a meaning to the scanner
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_H     = 8'h68;
    localparam logic [7:0] CHAR_R     = 8'h72;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AFTER_LT,
        MODE_OPEN,
        MODE_CLOSE
    } scan_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        STACK_HOLD,
        STACK_PUSH,
        STACK_POP
    } stack_op_t;

    typedef struct packed {
        stack_op_t op;
    } stack_cmd_t;

    typedef struct packed {
        logic                   last;
        logic [DEPTH_OUT_W-1:0] depth;
        status_t                status;
    } result_t;

endpackage

// ----- rtl/core/mtbc_stack_cell.sv -----
`timescale 1ns / 1ps

module mtbc_stack_cell #(
    parameter int NAME_W = 128,
    parameter int LEN_W  = 5
) (
    input  logic                aclk,
    input  mtbc_pkg::stack_cmd_t cmd,
    input  logic [NAME_W-1:0]   prev_name,
    input  logic [LEN_W-1:0]    prev_len,
    input  logic [NAME_W-1:0]   next_name,
    input  logic [LEN_W-1:0]    next_len,
    output logic [NAME_W-1:0]   name_q,
    output logic [LEN_W-1:0]    len_q
);

    logic [NAME_W-1:0] name_reg, name_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // Shift down on push, up on pop, else hold
    always_comb begin
        name_next = name_reg;
        len_next  = len_reg;
        case (cmd.op)
            mtbc_pkg::STACK_PUSH: begin
                name_next = prev_name;
                len_next  = prev_len;
            end
            mtbc_pkg::STACK_POP: begin
                name_next = next_name;
                len_next  = next_len;
            end
            default: begin
                name_next = name_reg;
                len_next  = len_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
        len_reg  <= len_next;
    end

    assign name_q = name_reg;
    assign len_q  = len_reg;

endmodule

// ----- rtl/core/mtbc_scanner.sv -----
`timescale 1ns / 1ps

module mtbc_scanner #(
    parameter int TAG_CHARS   = mtbc_pkg::TAG_CHARS_DEF,
    parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DEF,
    parameter int NAME_W      = TAG_CHARS * 8,
    parameter int LEN_W       = $clog2(TAG_CHARS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           char_in,
    input  logic                 last_char,
    input  logic [NAME_W-1:0]    top_name,
    input  logic [LEN_W-1:0]     top_len,
    output mtbc_pkg::stack_cmd_t cmd,
    output logic [NAME_W-1:0]    push_name,
    output logic [LEN_W-1:0]     push_len,
    output mtbc_pkg::result_t    result
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    mtbc_pkg::scan_mode_t mode_reg, mode_next;
    mtbc_pkg::status_t    err_reg, err_next;
    logic [NAME_W-1:0]    buf_reg, buf_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;

    logic append;
    logic finish;
    logic closing;
    logic is_void;
    logic top_match;

    // Void tags br and hr bypass the stack
    always_comb begin
        is_void = (len_reg == LEN_W'(2)) && (buf_reg[15:8] == mtbc_pkg::CHAR_R) &&
                  ((buf_reg[7:0] == mtbc_pkg::CHAR_B) || (buf_reg[7:0] == mtbc_pkg::CHAR_H));
    end

    // Compare the collected name with the stack top over its length only
    always_comb begin
        top_match = (top_len == len_reg);
        for (int i = 0; i < TAG_CHARS; i++) begin
            if ((LEN_W'(i) < len_reg) && (top_name[i*8 +: 8] != buf_reg[i*8 +: 8])) begin
                top_match = 1'b0;
            end
        end
    end

    // Next state of the scanner and the stack command
    always_comb begin
        mode_next  = mode_reg;
        err_next   = err_reg;
        buf_next   = buf_reg;
        len_next   = len_reg;
        depth_next = depth_reg;
        cmd.op     = mtbc_pkg::STACK_HOLD;
        append     = 1'b0;
        finish     = 1'b0;
        closing    = 1'b0;

        if (in_accept && (err_reg == mtbc_pkg::ST_OK)) begin
            unique case (mode_reg)
                mtbc_pkg::MODE_IDLE: begin
                    if (char_in == mtbc_pkg::CHAR_LT) begin
                        mode_next = mtbc_pkg::MODE_AFTER_LT;
                        len_next  = '0;
                    end
                end
                mtbc_pkg::MODE_AFTER_LT: begin
                    if (char_in == mtbc_pkg::CHAR_SLASH) begin
                        mode_next = mtbc_pkg::MODE_CLOSE;
                    end else if (char_in == mtbc_pkg::CHAR_GT) begin
                        finish = 1'b1;
                    end else if (char_in == mtbc_pkg::CHAR_LT) begin
                        mode_next = mtbc_pkg::MODE_AFTER_LT;
                        len_next  = '0;
                    end else begin
                        append    = 1'b1;
                        mode_next = mtbc_pkg::MODE_OPEN;
                    end
                end
                default: begin
                    if (char_in == mtbc_pkg::CHAR_GT) begin
                        finish  = 1'b1;
                        closing = (mode_reg == mtbc_pkg::MODE_CLOSE);
                    end else if (char_in == mtbc_pkg::CHAR_LT) begin
                        mode_next = mtbc_pkg::MODE_AFTER_LT;
                        len_next  = '0;
                    end else begin
                        append = 1'b1;
                    end
                end
            endcase
        end

        // Store one name byte, or flag an over-long name
        if (append) begin
            if (len_reg >= LEN_W'(TAG_CHARS)) begin
                err_next = mtbc_pkg::ST_TOO_LONG;
            end else begin
                for (int i = 0; i < TAG_CHARS; i++) begin
                    if (LEN_W'(i) == len_reg) begin
                        buf_next[i*8 +: 8] = char_in;
                    end
                end
                len_next = len_reg + LEN_W'(1);
            end
        end

        // Push, pop or flag at the end of a tag
        if (finish) begin
            if (!is_void) begin
                if (!closing) begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                        err_next = mtbc_pkg::ST_FULL;
                    end else begin
                        cmd.op     = mtbc_pkg::STACK_PUSH;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                end else if (depth_reg == '0) begin
                    err_next = mtbc_pkg::ST_EMPTY;
                end else if (!top_match) begin
                    err_next = mtbc_pkg::ST_MISMATCH;
                end else begin
                    cmd.op     = mtbc_pkg::STACK_POP;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
            end
            mode_next = mtbc_pkg::MODE_IDLE;
            len_next  = '0;
        end
    end

    // Advance on each transfer; the final character returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= mtbc_pkg::MODE_IDLE;
            err_reg   <= mtbc_pkg::ST_OK;
            len_reg   <= '0;
            depth_reg <= '0;
        end else if (in_accept && last_char) begin
            mode_reg  <= mtbc_pkg::MODE_IDLE;
            err_reg   <= mtbc_pkg::ST_OK;
            len_reg   <= '0;
            depth_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            err_reg   <= err_next;
            len_reg   <= len_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign push_name     = buf_reg;
    assign push_len      = len_reg;
    assign result.last   = last_char;
    assign result.depth  = mtbc_pkg::DEPTH_OUT_W'(depth_next);
    assign result.status = err_next;

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(TAG_CHARS))
        else $error("tag length beyond buffer size");

    a_sticky_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != mtbc_pkg::ST_OK) && !(in_accept && last_char)
        |=> $stable(err_reg) && $stable(depth_reg))
        else $error("error or stack changed after an error");

endmodule

// ----- rtl/core/markup_tag_balance_checker.sv -----
`timescale 1ns / 1ps

// Tag balance checker for a markup byte stream. Each transfer carries one
// character; every character yields one result transfer holding the sticky
// status and the number of open tags after that character, and tlast on the
// result marks the verdict for the whole text, after which all state returns
// to reset. One character is taken per cycle while the skid entry is empty.
// The tag stack is a chain of STACK_DEPTH cells with the top in the first
// cell; a push or pop shifts the whole chain in the same cycle, so the
// compare of a closing tag only ever sees the first cell. A two-entry output
// buffer takes one more result during a downstream stall. Unclosed tags at
// the end are not an error: judge them by the depth in the final result.
module markup_tag_balance_checker #(
    parameter int TAG_CHARS   = mtbc_pkg::TAG_CHARS_DEF,
    parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mtbc_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in
    input  logic                           s_tlast,   // last_char
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mtbc_pkg::M_TDATA_W-1:0] m_tdata,   // [2:0] status, [9:3] open_depth
    output logic                           m_tlast    // final_flag
);

    localparam int NAME_W = TAG_CHARS * 8;
    localparam int LEN_W  = $clog2(TAG_CHARS + 1);
    localparam int PAD_W  = mtbc_pkg::M_TDATA_W - mtbc_pkg::DEPTH_OUT_W - mtbc_pkg::STATUS_W;

    logic                 in_accept;
    mtbc_pkg::stack_cmd_t cmd;
    mtbc_pkg::result_t    result;
    logic [NAME_W-1:0]    push_name;
    logic [LEN_W-1:0]     push_len;
    logic [NAME_W-1:0]    cell_name [STACK_DEPTH];
    logic [LEN_W-1:0]     cell_len  [STACK_DEPTH];

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mtbc_pkg::result_t out_data_reg, out_data_next;
    mtbc_pkg::result_t skid_data_reg, skid_data_next;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    mtbc_scanner #(
        .TAG_CHARS   (TAG_CHARS),
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_W      (NAME_W),
        .LEN_W       (LEN_W)
    ) u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .char_in   (s_tdata),
        .last_char (s_tlast),
        .top_name  (cell_name[0]),
        .top_len   (cell_len[0]),
        .cmd       (cmd),
        .push_name (push_name),
        .push_len  (push_len),
        .result    (result)
    );

    // Chain of stack cells, top first
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [NAME_W-1:0] prev_name, next_name;
        logic [LEN_W-1:0]  prev_len, next_len;

        if (i == 0) begin : g_head
            assign prev_name = push_name;
            assign prev_len  = push_len;
        end else begin : g_body
            assign prev_name = cell_name[i-1];
            assign prev_len  = cell_len[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_tail
            assign next_name = cell_name[i];
            assign next_len  = cell_len[i];
        end else begin : g_link
            assign next_name = cell_name[i+1];
            assign next_len  = cell_len[i+1];
        end

        mtbc_stack_cell #(
            .NAME_W (NAME_W),
            .LEN_W  (LEN_W)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .prev_name (prev_name),
            .prev_len  (prev_len),
            .next_name (next_name),
            .next_len  (next_len),
            .name_q    (cell_name[i]),
            .len_q     (cell_len[i])
        );
    end

    // Output register plus skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (in_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg.depth, out_data_reg.status};
    assign m_tlast  = out_data_reg.last;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && out_valid_reg && !m_tready |=> skid_valid_reg && out_valid_reg)
        else $error("result lost on output stall");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mtbc_pkg::*;

    localparam int TAG_N        = TAG_CHARS_DEF;
    localparam int DEPTH_N      = STACK_DEPTH_DEF;
    localparam int N_ITEMS      = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int DEPTH_LSB    = STATUS_W;
    localparam int PAD_LSB      = STATUS_W + DEPTH_OUT_W;

    localparam logic [7:0] CHAR_A = "a";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct packed {
        logic [TAG_N*8-1:0] bytes;
        int                 len;
    } tag_name_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Scanner and tag stack mirror
    scan_mode_t  scan_st;
    logic [7:0]  name_buf [TAG_N];
    int          name_len;
    logic [7:0]  stk_name [DEPTH_N][TAG_N];
    int          stk_len [DEPTH_N];
    int          open_cnt;
    status_t     sticky_err;
    result_t     verdict_q [$];

    // Stimulus
    logic [7:0]  txt [$];
    text_char_t  char_q [$];

    // Handshake bookkeeping
    bit          s_taken;
    int          chars_in;
    int          idle_cycles;
    int          mismatches;

    markup_tag_balance_checker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Tag balance prediction
    // ---------------------------------------------------------------

    task automatic clear_scanner();
        scan_st    = MODE_IDLE;
        name_len   = 0;
        open_cnt   = 0;
        sticky_err = ST_OK;
        foreach (name_buf[i]) name_buf[i] = '0;
    endtask

    task automatic append_name_char(input logic [7:0] c);
        if (name_len >= TAG_N) begin
            sticky_err = ST_TOO_LONG;
        end else begin
            name_buf[name_len] = c;
            name_len++;
        end
    endtask

    // Push an opening name, or pop on a matching closing name; br and hr pass by
    task automatic finish_name(input bit closing);
        bit void_tag;
        bit same;
        int top;
        void_tag = (name_len == 2) && (name_buf[0] == CHAR_B || name_buf[0] == CHAR_H)
                   && (name_buf[1] == CHAR_R);
        if (!void_tag) begin
            if (!closing) begin
                if (open_cnt >= DEPTH_N) begin
                    sticky_err = ST_FULL;
                end else begin
                    for (int i = 0; i < TAG_N; i++) stk_name[open_cnt][i] = name_buf[i];
                    stk_len[open_cnt] = name_len;
                    open_cnt++;
                end
            end else if (open_cnt == 0) begin
                sticky_err = ST_EMPTY;
            end else begin
                top  = open_cnt - 1;
                same = (stk_len[top] == name_len);
                for (int i = 0; i < name_len; i++) begin
                    if (stk_name[top][i] != name_buf[i]) same = 1'b0;
                end
                if (same) open_cnt = top;
                else sticky_err = ST_MISMATCH;
            end
        end
        scan_st  = MODE_IDLE;
        name_len = 0;
    endtask

    task automatic predict_verdict(input logic [7:0] c, input logic last);
        result_t r;
        // Freeze scanner and stack once an error is held
        if (sticky_err == ST_OK) begin
            case (scan_st)
                MODE_IDLE: begin
                    if (c == CHAR_LT) begin
                        scan_st  = MODE_AFTER_LT;
                        name_len = 0;
                    end
                end
                MODE_AFTER_LT: begin
                    if (c == CHAR_SLASH) begin
                        scan_st = MODE_CLOSE;
                    end else if (c == CHAR_GT) begin
                        finish_name(1'b0);
                    end else if (c == CHAR_LT) begin
                        name_len = 0;
                    end else begin
                        append_name_char(c);
                        scan_st = MODE_OPEN;
                    end
                end
                default: begin
                    if (c == CHAR_GT) begin
                        finish_name(scan_st == MODE_CLOSE);
                    end else if (c == CHAR_LT) begin
                        scan_st  = MODE_AFTER_LT;
                        name_len = 0;
                    end else begin
                        append_name_char(c);
                    end
                end
            endcase
        end
        r.status = sticky_err;
        r.depth  = 7'(open_cnt);
        r.last   = last;
        verdict_q.push_back(r);
        // End of text returns everything to its reset state
        if (last) clear_scanner();
    endtask

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 8) return CHAR_A + 8'($urandom_range(0, 25));
        do b = 8'($urandom); while (b == CHAR_LT || b == CHAR_GT);
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHAR_LT);
        return b;
    endfunction

    function automatic int pick_name_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, TAG_N - 1);
        return TAG_N;
    endfunction

    function automatic tag_name_t rand_name(input int n);
        tag_name_t nm;
        nm.bytes = '0;
        nm.len   = n;
        for (int i = 0; i < n; i++) nm.bytes[i*8 +: 8] = name_byte();
        // A slash right after '<' would turn the tag into a closing one
        if (n > 0 && nm.bytes[7:0] == CHAR_SLASH) nm.bytes[7:0] = CHAR_A;
        return nm;
    endfunction

    task automatic emit_tag(input tag_name_t nm, input bit closing);
        txt.push_back(CHAR_LT);
        if (closing) txt.push_back(CHAR_SLASH);
        for (int i = 0; i < nm.len; i++) txt.push_back(nm.bytes[i*8 +: 8]);
        txt.push_back(CHAR_GT);
    endtask

    // Mostly properly nested markup, with occasional wrong or stray closes
    task automatic gen_nested_text();
        tag_name_t open_q [$];
        tag_name_t nm;
        int        r;
        repeat ($urandom_range(2, 24)) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                nm = rand_name(pick_name_len());
                emit_tag(nm, 1'b0);
                open_q.push_back(nm);
            end else if (r < 65 && open_q.size() > 0) begin
                nm = open_q.pop_back();
                if ($urandom_range(0, 9) == 0) begin
                    if (nm.len > 0 && $urandom_range(0, 1) == 1) begin
                        nm.bytes[7:0] = (nm.bytes[7:0] == CHAR_A) ? CHAR_H : CHAR_A;
                    end else if (nm.len < TAG_N) begin
                        nm.bytes[nm.len*8 +: 8] = CHAR_A;
                        nm.len++;
                    end else begin
                        nm.len--;
                    end
                end
                emit_tag(nm, 1'b1);
            end else if (r < 75) begin
                nm.bytes       = '0;
                nm.len         = 2;
                nm.bytes[7:0]  = $urandom_range(0, 1) ? CHAR_B : CHAR_H;
                nm.bytes[15:8] = CHAR_R;
                emit_tag(nm, $urandom_range(0, 3) == 0);
            end else if (r < 80) begin
                emit_tag(rand_name(pick_name_len()), 1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) txt.push_back(text_byte());
            end
        end
        if ($urandom_range(0, 9) < 7) begin
            while (open_q.size() > 0) emit_tag(open_q.pop_back(), 1'b1);
        end
    endtask

    task automatic gen_long_name_text();
        int n;
        repeat ($urandom_range(0, 3)) emit_tag(rand_name(pick_name_len()), 1'b0);
        txt.push_back(CHAR_LT);
        if ($urandom_range(0, 1)) txt.push_back(CHAR_SLASH);
        n = $urandom_range(TAG_N + 1, TAG_N + 4);
        for (int i = 0; i < n; i++) txt.push_back(i == 0 ? CHAR_A : name_byte());
        txt.push_back(CHAR_GT);
        repeat ($urandom_range(0, 6)) txt.push_back(text_byte());
    endtask

    // Fill the stack to the brim, and one past it on overflow
    task automatic gen_fill_text(input bit overflow);
        tag_name_t nm;
        int        n;
        n = overflow ? DEPTH_N + 1 : DEPTH_N;
        repeat (n) begin
            nm.bytes = '0;
            nm.len   = $urandom_range(0, 1);
            if (nm.len > 0) nm.bytes[7:0] = CHAR_A + 8'($urandom_range(0, 25));
            emit_tag(nm, 1'b0);
        end
        repeat ($urandom_range(1, 4)) emit_tag(nm, 1'b1);
    endtask

    task automatic gen_noise_text();
        logic [7:0] marks [6];
        marks = '{CHAR_LT, CHAR_GT, CHAR_SLASH, CHAR_B, CHAR_H, CHAR_R};
        repeat ($urandom_range(1, 12)) begin
            txt.push_back($urandom_range(0, 1) ? marks[$urandom_range(0, 5)] : 8'($urandom));
        end
    endtask

    // Move the built text into the send queue, marking its final character
    task automatic queue_text();
        text_char_t tc;
        foreach (txt[i]) begin
            tc.ch   = txt[i];
            tc.last = (i == txt.size() - 1);
            char_q.push_back(tc);
        end
        txt.delete();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        int r;
        clear_scanner();

        // Stray '>', '<' inside a tag, extreme bytes, br, empty names, close on empty
        txt = '{8'h00, CHAR_GT, CHAR_LT, 8'hFF, CHAR_LT, CHAR_B, CHAR_R, CHAR_GT,
                CHAR_LT, CHAR_GT, CHAR_LT, CHAR_SLASH, CHAR_GT,
                CHAR_LT, CHAR_SLASH, CHAR_GT};
        queue_text();
        // Mismatched close
        txt = '{CHAR_LT, CHAR_A, CHAR_GT, CHAR_LT, CHAR_SLASH, CHAR_B, CHAR_GT};
        queue_text();

        gen_fill_text(1'b1);
        queue_text();
        gen_long_name_text();
        queue_text();
        while (char_q.size() < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65) gen_nested_text();
            else if (r < 73) gen_long_name_text();
            else if (r < 75) gen_fill_text($urandom_range(0, 1));
            else gen_noise_text();
            queue_text();
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for all input, then for the results to drain
        while (char_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (verdict_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Sender: offer one character per transfer, with random gaps
    // ---------------------------------------------------------------

    text_char_t next_char;
    int         send_gap;
    bit         send_quiet;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            s_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (char_q.size() > 0) begin
                next_char = char_q.pop_front();
                s_tdata  <= next_char.ch;
                s_tlast  <= next_char.last;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold to back up the input
    // ---------------------------------------------------------------

    int stall_left;
    int hold_left;
    bit hold_done;
    bit recv_quiet;

    always @(negedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && chars_in >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rdy       = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
            stall_left = recv_quiet ? 0 : pick_gap();
        end
        m_tready <= rdy;
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers
    // ---------------------------------------------------------------

    result_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_verdict(s_tdata, s_tlast);
                s_taken = 1'b1;
                chars_in++;
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: tdata=%h tlast=%b", m_tdata, m_tlast);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status
                        || m_tdata[DEPTH_LSB +: DEPTH_OUT_W] !== want.depth
                        || m_tdata[M_TDATA_W-1:PAD_LSB] !== '0
                        || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch: expected status=%0d depth=%0d last=%b, got status=%0d depth=%0d pad=%h last=%b",
                                     want.status, want.depth, want.last,
                                     m_tdata[STATUS_W-1:0], m_tdata[DEPTH_LSB +: DEPTH_OUT_W],
                                     m_tdata[M_TDATA_W-1:PAD_LSB], m_tlast);
                        end
                    end
                end
            end
            // Watchdog on cycles with no transfer on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
